>>> design/wsm_pkg.sv
// ----------------------------------------------------------------------------
// wsm_pkg: shared types, constants and helpers for the wildcard matcher
// Pattern geometry, register indexes, verdict codes and the literal search.
// ----------------------------------------------------------------------------
`default_nettype none

package wsm_pkg;

  // pattern geometry
  localparam int PATTERN_CHARS = 32;
  localparam int CHAR_W        = 8;
  localparam int POS_W         = $clog2(PATTERN_CHARS);
  localparam int IDX_W         = 6;
  localparam int PATTERN_W     = PATTERN_CHARS * CHAR_W;

  localparam logic [CHAR_W-1:0] WILDCARD = 8'h3F;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WORD_CHARS = CFG_DATA_W / CHAR_W;

  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_3 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LENGTH    = 3'd4;

  // stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // verdict codes
  localparam logic [1:0] VERDICT_OPEN  = 2'd0;
  localparam logic [1:0] VERDICT_MATCH = 2'd1;
  localparam logic [1:0] VERDICT_FAIL  = 2'd2;

  // one character handed to the matcher
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] text_char;
    logic              final_char;
  } step_t;

  // lowest literal position at or after start: {found, position}
  function automatic logic [POS_W:0] first_from(
    input logic [PATTERN_CHARS-1:0] mask,
    input logic [IDX_W-1:0]         start
  );
    logic             found;
    logic [POS_W-1:0] pos;
    found = 1'b0;
    pos   = '0;
    for (int i = PATTERN_CHARS - 1; i >= 0; i--) begin
      if (mask[i] && (IDX_W'(i) >= start)) begin
        found = 1'b1;
        pos   = POS_W'(i);
      end
    end
    return {found, pos};
  endfunction

endpackage

`default_nettype wire

>>> design/wsm_matcher.sv
// ----------------------------------------------------------------------------
// wsm_matcher: greedy wildcard match state for one text at a time
// Holds the pattern position, skip flag and verdict, advances them by one
// text character per step and returns the verdict as of that character.
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_matcher (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [wsm_pkg::PATTERN_W-1:0]  pattern,
  input  wire logic [wsm_pkg::IDX_W-1:0]      pattern_length,
  input  wire wsm_pkg::step_t                 step,
  output logic                                matched
);
  import wsm_pkg::*;

  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     skip_r, skip_nxt;
  logic [1:0]               verd_r, verd_nxt;

  logic [IDX_W-1:0]         used_len;
  logic [CHAR_W-1:0]        chars [PATTERN_CHARS];
  logic [PATTERN_CHARS-1:0] lit;
  logic                     p_in;
  logic                     cur_eq;
  logic [POS_W:0]           q_hit;
  logic [POS_W:0]           tail_hit;
  logic                     q_eq;

  // clamp length, split pattern into characters, mark literals in range
  assign used_len = (pattern_length > IDX_W'(PATTERN_CHARS)) ? IDX_W'(PATTERN_CHARS)
                                                             : pattern_length;
  always_comb begin
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      chars[i] = pattern[i*CHAR_W +: CHAR_W];
      lit[i]   = (IDX_W'(i) < used_len) && (chars[i] != WILDCARD);
    end
  end

  // compare at the current position and at the next literal
  assign p_in   = idx_r < used_len;
  assign cur_eq = p_in && (chars[idx_r[POS_W-1:0]] == step.text_char);
  assign q_hit  = first_from(lit, idx_r);
  assign q_eq   = chars[q_hit[POS_W-1:0]] == step.text_char;

  // consume one character
  always_comb begin
    idx_nxt  = idx_r;
    skip_nxt = skip_r;
    verd_nxt = verd_r;
    if (verd_r == VERDICT_OPEN) begin
      if (skip_r) begin
        if (cur_eq) begin
          idx_nxt  = idx_r + IDX_W'(1);
          skip_nxt = 1'b0;
        end
      end else if (!p_in) begin
        verd_nxt = VERDICT_FAIL;
      end else if (!q_hit[POS_W]) begin
        // only wildcards remain: match at once
        verd_nxt = VERDICT_MATCH;
        idx_nxt  = used_len;
      end else if (q_eq) begin
        idx_nxt = IDX_W'(q_hit[POS_W-1:0]) + IDX_W'(1);
      end else if (IDX_W'(q_hit[POS_W-1:0]) == idx_r) begin
        // literal at the current position mismatched
        verd_nxt = VERDICT_FAIL;
      end else begin
        idx_nxt  = IDX_W'(q_hit[POS_W-1:0]);
        skip_nxt = 1'b1;
      end
    end
  end

  // verdict at end of text: trailing wildcards count as matched
  assign tail_hit = first_from(lit, idx_nxt);
  assign matched  = (verd_nxt == VERDICT_MATCH) ||
                    ((verd_nxt == VERDICT_OPEN) && !skip_nxt && !tail_hit[POS_W]);

  // update state; restart after the final character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      skip_r <= 1'b0;
      verd_r <= VERDICT_OPEN;
    end else if (step.valid) begin
      if (step.final_char) begin
        idx_r  <= '0;
        skip_r <= 1'b0;
        verd_r <= VERDICT_OPEN;
      end else begin
        idx_r  <= idx_nxt;
        skip_r <= skip_nxt;
        verd_r <= verd_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/wildcard_signature_match.sv
// A final character beat is registered in the input stage, then its verdict in the result register.
// Throughput: one text character per cycle unless a final character waits on a held verdict;
// the matcher settles each character combinationally via a next-literal priority encoder.
// Reset (synchronous, rst_n low): clears the pattern and length registers, the match state,
// and empties the input and result stages.
// ----------------------------------------------------------------------------
// wildcard_signature_match: stream text against a '?' wildcard pattern
// Input stage, single-pass matcher and result register with a plain
// configuration write port for the 32-byte pattern and its length.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_signature_match (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [wsm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [wsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // text stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [wsm_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] text_char
  input  wire logic                            in_tlast,   // final_char
  // verdict stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [wsm_pkg::OUT_DATA_W-1:0]       out_tdata   // [0] matched, [7:1] zero
);
  import wsm_pkg::*;

  logic [PATTERN_W-1:0] pattern_r;
  logic [IDX_W-1:0]     length_r;

  logic                 s1_v_r, s1_v_nxt;
  logic [CHAR_W-1:0]    s1_char_r;
  logic                 s1_last_r;

  logic                 out_v_r, out_v_nxt;
  logic                 out_matched_r;

  logic                 in_beat;
  logic                 advance;
  logic                 matched;
  step_t                step;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PATTERN_0: pattern_r[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        REG_PATTERN_1: pattern_r[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        REG_PATTERN_2: pattern_r[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        REG_PATTERN_3: pattern_r[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        REG_LENGTH:    length_r <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the input stage unless a verdict has nowhere to go
  assign advance   = s1_v_r && (!s1_last_r || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_beat) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_char_r <= in_tdata[CHAR_W-1:0];
      s1_last_r <= in_tlast;
    end
  end

  // match one character per advance
  assign step.valid      = advance;
  assign step.text_char  = s1_char_r;
  assign step.final_char = s1_last_r;

  wsm_matcher u_matcher (
    .clk            (clk),
    .rst_n          (rst_n),
    .pattern        (pattern_r),
    .pattern_length (length_r),
    .step           (step),
    .matched        (matched)
  );

  // hold the verdict until taken
  always_comb begin
    out_v_nxt = out_v_r;
    if (advance && s1_last_r) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_matched_r <= matched;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_DATA_W-1)'(0), out_matched_r};

endmodule

`default_nettype wire

>>> design/wsm_checker.sv
// ----------------------------------------------------------------------------
// wsm_checker: port-level assertions for the wildcard matcher
// Watches the stream ports of the top level; attached by bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            in_tlast,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [wsm_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import wsm_pkg::*;

  // hold a stalled verdict beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict beat changed while stalled");

  // result stage is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("verdict beat present after reset");

  // a fresh verdict follows a final character beat through the input stage and result register
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("verdict without a final character beat");

  // with the result stage empty the input side is never blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result stage");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:1] == '0)
    else $error("nonzero padding in verdict beat");

endmodule

bind wildcard_signature_match wsm_checker u_wsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> tb/wildcard_signature_match_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_signature_match_test: self-checking bench for the wildcard matcher
// Streams text against configured '?' patterns, tracks the match
// state alongside the block and compares every verdict beat in order.
// ----------------------------------------------------------------------------

module wildcard_signature_match_test;

  import wsm_pkg::*;

  localparam int ITEM_TARGET    = 1500;
  localparam int TAIL_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] text_char
  logic                  in_tlast;   // final_char
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] matched, [7:1] zero

  // mirror of the pattern registers and the per-text match state
  logic [63:0]  pat_word [4];
  logic [5:0]   pat_len;
  int unsigned  scan_pos;
  logic         in_skip;
  logic [1:0]   text_state;

  logic         expected_verdicts [$];
  logic [7:0]   text_buf [$];
  int unsigned  items_sent;
  int unsigned  fail_count;
  int unsigned  quiet_cycles;
  logic         sender_idles;
  logic         receiver_stalls;

  wildcard_signature_match i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Match state tracking
  // ---------------------------------------------------------------------------

  function automatic int unsigned live_length();
    return (pat_len > PATTERN_CHARS) ? PATTERN_CHARS : pat_len;
  endfunction

  function automatic logic [7:0] pat_char(int unsigned i);
    return pat_word[(i >> 3) & 3][(i & 7) * 8 +: 8];
  endfunction

  // first non-wildcard position at or after i, or n
  function automatic int unsigned next_literal(int unsigned i, int unsigned n);
    while (i < n && pat_char(i) == WILDCARD) i++;
    return i;
  endfunction

  task automatic note_reg_write(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
    case (addr)
      REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
        pat_word[addr] = data;
      end
      REG_LENGTH: begin
        pat_len = data[5:0];
      end
      default: ;
    endcase
  endtask

  task automatic advance_match(input logic [7:0] c);
    int unsigned n;
    int unsigned p;
    n = live_length();
    p = scan_pos;
    if (in_skip) begin
      // wait for the literal that closes the wildcard run
      if (p < n && pat_char(p) == c) begin
        scan_pos = p + 1;
        in_skip  = 1'b0;
      end
    end else if (p >= n) begin
      text_state = VERDICT_FAIL;
    end else if (pat_char(p) == WILDCARD) begin
      p = next_literal(p, n);
      if (p >= n) begin
        text_state = VERDICT_MATCH;
        scan_pos   = p;
      end else if (pat_char(p) == c) begin
        scan_pos = p + 1;
      end else begin
        scan_pos = p;
        in_skip  = 1'b1;
      end
    end else if (pat_char(p) != c) begin
      text_state = VERDICT_FAIL;
    end else begin
      scan_pos = p + 1;
    end
  endtask

  task automatic track_char(input logic [7:0] c, input logic last);
    logic        verdict;
    int unsigned n;
    if (text_state == VERDICT_OPEN) advance_match(c);
    if (last) begin
      n = live_length();
      if (text_state == VERDICT_MATCH) begin
        verdict = 1'b1;
      end else if (text_state == VERDICT_FAIL || in_skip) begin
        verdict = 1'b0;
      end else begin
        verdict = (next_literal(scan_pos, n) >= n);
      end
      expected_verdicts.push_back(verdict);
      scan_pos   = 0;
      in_skip    = 1'b0;
      text_state = VERDICT_OPEN;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_char(input logic [7:0] ch, input logic last);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    track_char(ch, last);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text_buf();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  // hold off the sender until every verdict is back and the pipe is empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    note_reg_write(addr, data);
    @(posedge clk);
  endtask

  task automatic program_pattern(input logic [63:0] w0, input logic [63:0] w1,
                                 input logic [63:0] w2, input logic [63:0] w3,
                                 input logic [63:0] len_word);
    put_reg(REG_PATTERN_0, w0);
    put_reg(REG_PATTERN_1, w1);
    put_reg(REG_PATTERN_2, w2);
    put_reg(REG_PATTERN_3, w3);
    put_reg(REG_LENGTH, len_word);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pack_chars(string s, int k);
    logic [63:0] w;
    w = '0;
    for (int b = 0; b < 8; b++) begin
      if (k * 8 + b < s.len()) w[b * 8 +: 8] = s[k * 8 + b];
    end
    return w;
  endfunction

  task automatic load_string_pattern(input string s, input logic [63:0] len_word);
    program_pattern(pack_chars(s, 0), pack_chars(s, 1), pack_chars(s, 2), pack_chars(s, 3),
                    len_word);
  endtask

  // text bytes drawn mostly from the pattern's own alphabet
  function automatic logic [7:0] filler_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return pat_char($urandom_range(0, PATTERN_CHARS - 1));
      default: return 8'h61 + 8'($urandom_range(0, 3));
    endcase
  endfunction

  // build one text: mostly shaped after the pattern, some pure noise
  task automatic compose_text();
    logic [7:0] ch;
    text_buf.delete();
    if ($urandom_range(0, 9) < 7) begin
      for (int i = 0; i < live_length(); i++) begin
        ch = pat_char(i);
        if (ch == WILDCARD) begin
          repeat ($urandom_range(0, 2)) text_buf.push_back(filler_char());
        end else if ($urandom_range(0, 29) == 0) begin
          text_buf.push_back(filler_char());
        end else begin
          text_buf.push_back(ch);
        end
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) text_buf.push_back(filler_char());
      end
      if ($urandom_range(0, 7) == 0 && text_buf.size() > 1) void'(text_buf.pop_back());
    end else begin
      repeat ($urandom_range(1, 8)) text_buf.push_back(filler_char());
    end
    if (text_buf.size() == 0) text_buf.push_back(filler_char());
  endtask

  task automatic program_random_pattern();
    logic [63:0] w [4];
    logic [63:0] len_word;
    int unsigned mode;
    int unsigned pick;
    int unsigned len;
    mode = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      for (int b = 0; b < 8; b++) begin
        if (mode == 0) begin
          w[k][b * 8 +: 8] = 8'($urandom_range(0, 255));
        end else if ($urandom_range(0, 2) == 0) begin
          w[k][b * 8 +: 8] = WILDCARD;
        end else begin
          w[k][b * 8 +: 8] = 8'h61 + 8'($urandom_range(0, 3));
        end
      end
    end
    // mostly short patterns, a few full or oversized ones
    pick = $urandom_range(0, 15);
    if (pick == 0)       len = 0;
    else if (pick < 10)  len = $urandom_range(1, 8);
    else if (pick < 12)  len = PATTERN_CHARS;
    else if (pick == 12) len = $urandom_range(33, 63);
    else                 len = $urandom_range(9, 31);
    len_word      = {$urandom, $urandom};
    len_word[5:0] = 6'(len);
    put_reg(REG_PATTERN_0, w[0]);
    put_reg(REG_PATTERN_1, w[1]);
    put_reg(REG_PATTERN_2, w[2]);
    put_reg(REG_PATTERN_3, w[3]);
    put_reg(REG_LENGTH, len_word);
    if ($urandom_range(0, 3) == 0) begin
      put_reg(CFG_ADDR_W'(REG_LENGTH + 1 + $urandom_range(0, 2)), {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset pattern is empty: any first character fails, zero byte included
  task automatic test_empty_pattern();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b1;
    send_char(8'h00, 1'b1);
    send_text("ab");
    wait_idle();
  endtask

  // skips inside runs, trailing runs, early verdicts, text past the pattern
  task automatic test_wildcard_runs();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b0;
    load_string_pattern("a?b", 64'd3);
    send_text("axxb");
    send_text("abbb");
    wait_idle();
    load_string_pattern("ab??", 64'd4);
    send_text("abqq");
    send_text("ab");
    wait_idle();
  endtask

  // zero and all-ones bytes are ordinary literals on both sides
  task automatic test_extreme_bytes();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    program_pattern({40'h0, 8'hFF, WILDCARD, 8'h00}, '0, '0, '0, 64'd3);
    send_char(8'h00, 1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b1);
    wait_idle();
  endtask

  // length above the pattern size clamps to the full 32 characters
  task automatic test_oversized_length();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    program_pattern({8{WILDCARD}}, {8{WILDCARD}}, {8{WILDCARD}}, {8'h5A, {7{WILDCARD}}},
                    64'hFFFF_FFFF_FFFF_FFFF);
    send_text("Z");
    send_text("Q");
    wait_idle();
  endtask

  // shrink the length under a text in progress
  task automatic test_pattern_change_mid_text();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    load_string_pattern("abcd", 64'd4);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    wait_idle();
    put_reg(REG_LENGTH, 64'd2);
    cfg_we <= 1'b0;
    send_char("c", 1'b1);
    wait_idle();
  endtask

  // writes to unmapped indexes leave the pattern alone
  task automatic test_spare_register_index();
    load_string_pattern("k?", 64'd2);
    for (int a = REG_LENGTH + 1; a < 2 ** CFG_ADDR_W; a++) begin
      put_reg(CFG_ADDR_W'(a), '1);
    end
    cfg_we <= 1'b0;
    send_text("k");
    wait_idle();
  endtask

  task automatic test_random_texts();
    int unsigned cut;
    while (items_sent < ITEM_TARGET) begin
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      program_random_pattern();
      repeat ($urandom_range(4, 16)) begin
        compose_text();
        send_text_buf();
      end
      // leave a text open across the next pattern load now and then
      if ($urandom_range(0, 2) == 0) begin
        compose_text();
        cut = $urandom_range(1, text_buf.size());
        for (int i = 0; i < cut; i++) send_char(text_buf[i], 1'b0);
      end
      wait_idle();
    end
    send_char(filler_char(), 1'b1);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    for (int k = 0; k < 4; k++) pat_word[k] = '0;
    pat_len         = '0;
    scan_pos        = 0;
    in_skip         = 1'b0;
    text_state      = VERDICT_OPEN;
    items_sent      = 0;
    fail_count      = 0;
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pattern();
    test_wildcard_runs();
    test_extreme_bytes();
    test_oversized_length();
    test_pattern_change_mid_text();
    test_spare_register_index();
    test_random_texts();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("verdicts still missing at end: %0d", expected_verdicts.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // accept verdict beats with random stalls and compare in order
  initial begin
    int unsigned stall;
    logic        want;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = receiver_stalls ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_verdicts.size() == 0) begin
        $error("verdict beat with nothing pending, matched %0b", out_tdata[0]);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_tdata[0] !== want) begin
          $error("matched expected %0b actual %0b", want, out_tdata[0]);
          fail_count++;
        end
      end
      if (out_tdata[7:1] !== '0) begin
        $error("padding expected 0 actual %0h", out_tdata[7:1]);
        fail_count++;
      end
    end
  end

  // drop the run if no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
